// ===== design/mbds_pkg.sv =====
// Shared constants, types and codes of the multiplexed BCD display scanner.
package mbds_pkg;

	localparam int MAX_DIGITS = 8;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
	localparam int VALUE_W    = 32;
	localparam int STEPS      = VALUE_W;
	localparam int STEP_W     = $clog2(STEPS);
	localparam int COUNT_W    = 4;
	localparam int DWELL_W    = 16;
	localparam int SEL_W      = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_W      = 8;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [BCD_W-1:0]   bcd_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIGIT_COUNT = 1'b0,
		CFG_DWELL_TICKS = 1'b1
	} cfg_idx_t;

	// Result word, bcd_lines in the lowest bits.
	typedef struct packed {
		logic             digit_on;
		logic [SEL_W-1:0] digit_select;
		digit_t           bcd_lines;
	} result_t;

endpackage

// ===== design/multiplexed_bcd_display_scanner.sv =====
// Top level: conversion sequencer, digit store, scan and dwell counters, result register.
// A tick result is registered in the output stage, or in the holding stage if stalled.
// A load request runs 32 conversion steps through one shared dabble unit, one bit
// per cycle; its result is registered after the 32nd step.
// A one-deep holding stage keeps a result on an output stall; no request is taken while full.
// arst_n clears the store, scan index, dwell counter and handshakes; registers go to 3 and 5.
module multiplexed_bcd_display_scanner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mbds_pkg::VALUE_W-1:0]        s_tdata,   // value
	input  logic                                s_tuser,   // command
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mbds_pkg::OUT_W-1:0]          m_tdata,   // bcd_lines, digit_select, digit_on
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mbds_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mbds_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mbds_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_CONV
	} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic [VALUE_W-1:0] shift_q;
	bcd_t               bcd_q;
	bcd_t               bcd_next;
	digit_t             store_q [MAX_DIGITS];
	digit_t             new_digits [MAX_DIGITS];
	logic [SEL_W-1:0]   scan_q;
	logic [DWELL_W-1:0] dwell_q;
	logic [COUNT_W-1:0] digit_count_q;
	logic [DWELL_W-1:0] dwell_ticks_q;
	logic [COUNT_W-1:0] n_act;

	logic               accept;
	logic               is_tick;
	logic               conv_done;
	logic [SEL_W-1:0]   cur_idx;
	logic [COUNT_W-1:0] inc_idx;
	logic [DWELL_W-1:0] dwell_inc;
	logic [DWELL_W-1:0] limit;
	logic [SEL_W-1:0]   tick_idx;
	logic [DWELL_W-1:0] tick_dwell;

	logic               res_valid;
	result_t            res;
	logic               m_valid_q;
	result_t            m_data_q;
	logic               pend_q;
	result_t            pend_data_q;
	logic               out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE) && !pend_q;
	assign accept    = s_tvalid && s_tready;
	assign is_tick   = (cmd_t'(s_tuser) == CMD_TICK);
	assign conv_done = (state_q == ST_CONV) && (step_q == STEP_W'(STEPS - 1));

	always_comb begin
		if (digit_count_q == '0) begin
			n_act = COUNT_W'(1);
		end else if (digit_count_q > COUNT_W'(MAX_DIGITS)) begin
			n_act = COUNT_W'(MAX_DIGITS);
		end else begin
			n_act = digit_count_q;
		end
	end

	mbds_dabble u_dabble (
		.bcd_in  (bcd_q),
		.bit_in  (shift_q[VALUE_W-1]),
		.bcd_out (bcd_next)
	);

	// Store slot j takes decimal digit n-1-j; slots at or past the count are cleared.
	always_comb begin
		for (int j = 0; j < MAX_DIGITS; j++) begin
			logic [COUNT_W-1:0] src;
			src = n_act - COUNT_W'(1) - COUNT_W'(j);
			if (COUNT_W'(j) < n_act) begin
				new_digits[j] = bcd_next[src[SEL_W-1:0]*DIGIT_W +: DIGIT_W];
			end else begin
				new_digits[j] = '0;
			end
		end
	end

	// Tick update: fix a stale scan index, advance the dwell, and the index at its limit.
	always_comb begin
		cur_idx   = ({1'b0, scan_q} >= n_act) ? '0 : scan_q;
		dwell_inc = dwell_q + DWELL_W'(1);
		limit     = (dwell_ticks_q == '0) ? DWELL_W'(1) : dwell_ticks_q;
		inc_idx   = {1'b0, cur_idx} + COUNT_W'(1);
		if (dwell_inc >= limit) begin
			tick_dwell = '0;
			tick_idx   = (inc_idx >= n_act) ? '0 : inc_idx[SEL_W-1:0];
		end else begin
			tick_dwell = dwell_inc;
			tick_idx   = cur_idx;
		end
	end

	always_comb begin
		res_valid        = (accept && is_tick) || conv_done;
		res.digit_on     = 1'b1;
		if (conv_done) begin
			res.digit_select = '0;
			res.bcd_lines    = new_digits[0];
		end else begin
			res.digit_select = tick_idx;
			res.bcd_lines    = store_q[tick_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= COUNT_W'(3);
			dwell_ticks_q <= DWELL_W'(5);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DIGIT_COUNT: digit_count_q <= cfg_data[COUNT_W-1:0];
				CFG_DWELL_TICKS: dwell_ticks_q <= cfg_data[DWELL_W-1:0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			scan_q  <= '0;
			dwell_q <= '0;
			for (int j = 0; j < MAX_DIGITS; j++) begin
				store_q[j] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_tick) begin
							scan_q  <= tick_idx;
							dwell_q <= tick_dwell;
						end else begin
							state_q <= ST_CONV;
							step_q  <= '0;
						end
					end
				end
				ST_CONV: begin
					step_q <= step_q + STEP_W'(1);
					if (conv_done) begin
						state_q <= ST_IDLE;
						scan_q  <= '0;
						dwell_q <= '0;
						for (int j = 0; j < MAX_DIGITS; j++) begin
							store_q[j] <= new_digits[j];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Conversion datapath: the value shifts out MSB first into the BCD accumulator.
	always_ff @(posedge clk) begin
		if (accept && !is_tick) begin
			shift_q <= s_tdata;
			bcd_q   <= '0;
		end else if (state_q == ST_CONV) begin
			shift_q <= {shift_q[VALUE_W-2:0], 1'b0};
			bcd_q   <= bcd_next;
		end
	end

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			pend_q    <= 1'b0;
		end else if (res_valid) begin
			if (out_free) begin
				m_valid_q <= 1'b1;
			end else begin
				pend_q <= 1'b1;
			end
		end else if (out_free) begin
			m_valid_q <= pend_q;
			pend_q    <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			if (out_free) begin
				m_data_q <= res;
			end else begin
				pend_data_q <= res;
			end
		end else if (out_free && pend_q) begin
			m_data_q <= pend_data_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_tick) |=> (state_q == ST_CONV) && (step_q == '0))
		else $error("load request did not start a conversion");

	a_conv_ends: assert property (@(posedge clk) disable iff (!arst_n)
		conv_done |=> (state_q == ST_IDLE) && m_valid_q && (scan_q == '0))
		else $error("conversion did not finish with a result");

	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> m_valid_q)
		else $error("held result without an output result");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> !s_tready)
		else $error("ready during conversion");

endmodule

// ===== design/mbds_dabble.sv =====
// One shift-and-add-3 step of the binary to BCD conversion over all digits.
module mbds_dabble (
	input  mbds_pkg::bcd_t bcd_in,
	input  logic           bit_in,
	output mbds_pkg::bcd_t bcd_out
);
	import mbds_pkg::*;

	bcd_t adj;

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_in[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end else begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	// The carry out of the top digit is dropped, which keeps the value modulo 10^MAX_DIGITS.
	assign bcd_out = {adj[BCD_W-2:0], bit_in};

endmodule
